/* rtl/cesc_pkg.sv */
// ----------------------------------------------------------------------------
// cesc_pkg
// Shared types and constants for the C escape sequence decoder.
// ----------------------------------------------------------------------------
package cesc_pkg;

	// entries in the queue between front and back
	localparam int unsigned QUEUE_DEPTH = 4;
	localparam int unsigned QPTR_BITS   = $clog2(QUEUE_DEPTH);

	// one classified input word: one or two results to emit
	typedef struct packed {
		logic       two;    // second result present
		logic       end0;   // first result is the end marker
		logic [7:0] byte0;
		logic       end1;   // second result is the end marker
		logic [7:0] byte1;
	} esc_op_t;

endpackage

/* rtl/cesc_front.sv */
// ----------------------------------------------------------------------------
// cesc_front
// Accepts source characters, tracks the escape scan state and turns each
// word into an operation of zero, one or two results for the queue.
// ----------------------------------------------------------------------------
module cesc_front
	import cesc_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	input  logic [7:0] in_byte,
	input  logic       q_full,
	output logic       in_stall,
	output logic       push,
	output esc_op_t    push_op
);

	typedef enum logic [3:0] {
		MODE_PLAIN = 4'b0001,
		MODE_ESC   = 4'b0010,
		MODE_OCT   = 4'b0100,
		MODE_HEX   = 4'b1000
	} scan_mode_t;

	localparam logic [7:0] CH_NUL    = 8'h00;
	localparam logic [7:0] CH_BSLASH = 8'h5C;
	localparam logic [7:0] CH_X      = 8'h78;
	localparam logic [7:0] CH_A      = 8'h61;
	localparam logic [7:0] CH_B      = 8'h62;
	localparam logic [7:0] CH_E      = 8'h65;
	localparam logic [7:0] CH_F      = 8'h66;
	localparam logic [7:0] CH_N      = 8'h6E;
	localparam logic [7:0] CH_R      = 8'h72;
	localparam logic [7:0] CH_T      = 8'h74;
	localparam logic [7:0] CH_V      = 8'h76;
	localparam logic [7:0] CODE_BEL  = 8'h07;
	localparam logic [7:0] CODE_BS   = 8'h08;
	localparam logic [7:0] CODE_ESC  = 8'h1B;
	localparam logic [7:0] CODE_FF   = 8'h0C;
	localparam logic [7:0] CODE_LF   = 8'h0A;
	localparam logic [7:0] CODE_CR   = 8'h0D;
	localparam logic [7:0] CODE_HT   = 8'h09;
	localparam logic [7:0] CODE_VT   = 8'h0B;
	localparam logic [1:0] OCT_LAST  = 2'd2;
	localparam logic [1:0] HEX_LAST  = 2'd1;

	// hex digit value, bit 4 set when the character is a hex digit
	function automatic logic [4:0] hex_digit(input logic [7:0] c);
		logic [4:0] r;
		r = 5'd0;
		if (c >= 8'h30 && c <= 8'h39) begin
			r = {1'b1, c[3:0]};
		end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
			r = {1'b1, c[3:0] + 4'd9};
		end
		return r;
	endfunction

	scan_mode_t mode_q, mode_n;
	logic [7:0] acc_q, acc_n;
	logic [1:0] dig_q, dig_n;
	logic       accept;
	logic       has;
	esc_op_t    op;
	logic       oct_dig;
	logic [4:0] hex_d;
	logic [7:0] acc_oct;
	logic [7:0] acc_hex;
	logic       c_end;
	logic       c_bslash;

	assign in_stall = q_full;
	assign accept   = in_valid && !q_full;
	assign push     = accept && has;
	assign push_op  = op;

	// classify the word against the scan state
	always_comb begin
		mode_n   = mode_q;
		acc_n    = acc_q;
		dig_n    = dig_q;
		has      = 1'b0;
		op       = '0;
		oct_dig  = (in_byte >= 8'h30) && (in_byte <= 8'h37);
		hex_d    = hex_digit(in_byte);
		acc_oct  = {acc_q[4:0], in_byte[2:0]};
		acc_hex  = {acc_q[3:0], hex_d[3:0]};
		c_end    = (in_byte == CH_NUL);
		c_bslash = (in_byte == CH_BSLASH);
		unique case (mode_q)
			MODE_PLAIN: begin
				if (c_bslash) begin
					mode_n = MODE_ESC;
				end else begin
					has       = 1'b1;
					op.end0   = c_end;
					op.byte0  = in_byte;
				end
			end
			MODE_ESC: begin
				mode_n = MODE_PLAIN;
				priority if (c_end) begin
					has     = 1'b1;
					op.end0 = 1'b1;
				end else if (in_byte == CH_X) begin
					mode_n = MODE_HEX;
					acc_n  = 8'd0;
					dig_n  = 2'd0;
				end else if (oct_dig) begin
					mode_n = MODE_OCT;
					acc_n  = {5'd0, in_byte[2:0]};
					dig_n  = 2'd1;
				end else begin
					has = 1'b1;
					unique case (in_byte)
						CH_A:    op.byte0 = CODE_BEL;
						CH_B:    op.byte0 = CODE_BS;
						CH_E:    op.byte0 = CODE_ESC;
						CH_F:    op.byte0 = CODE_FF;
						CH_N:    op.byte0 = CODE_LF;
						CH_R:    op.byte0 = CODE_CR;
						CH_T:    op.byte0 = CODE_HT;
						CH_V:    op.byte0 = CODE_VT;
						default: op.byte0 = in_byte;
					endcase
				end
			end
			MODE_OCT: begin
				if (oct_dig) begin
					acc_n = acc_oct;
					if (dig_q == OCT_LAST) begin
						has      = 1'b1;
						op.byte0 = acc_oct;
						mode_n   = MODE_PLAIN;
					end else begin
						dig_n = dig_q + 2'd1;
					end
				end else begin
					// number ended: its byte first, then the character as plain text, or a new escape on a backslash
					has      = 1'b1;
					op.byte0 = acc_q;
					if (c_bslash) begin
						mode_n = MODE_ESC;
					end else begin
						mode_n   = MODE_PLAIN;
						op.two   = 1'b1;
						op.end1  = c_end;
						op.byte1 = in_byte;
					end
				end
			end
			MODE_HEX: begin
				if (hex_d[4]) begin
					acc_n = acc_hex;
					if (dig_q == HEX_LAST) begin
						has      = 1'b1;
						op.byte0 = acc_hex;
						mode_n   = MODE_PLAIN;
					end else begin
						dig_n = dig_q + 2'd1;
					end
				end else begin
					has      = 1'b1;
					op.byte0 = acc_q;
					if (c_bslash) begin
						mode_n = MODE_ESC;
					end else begin
						mode_n   = MODE_PLAIN;
						op.two   = 1'b1;
						op.end1  = c_end;
						op.byte1 = in_byte;
					end
				end
			end
			default: begin
				mode_n = MODE_PLAIN;
			end
		endcase
	end

	// scan state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_PLAIN;
			acc_q  <= 8'd0;
			dig_q  <= 2'd0;
		end else if (accept) begin
			mode_q <= mode_n;
			acc_q  <= acc_n;
			dig_q  <= dig_n;
		end
	end

endmodule

/* rtl/cesc_fifo.sv */
// ----------------------------------------------------------------------------
// cesc_fifo
// Short first-in first-out queue of classified operations between the
// front and the back; head entry is visible without a read cycle.
// ----------------------------------------------------------------------------
module cesc_fifo
	import cesc_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    push,
	input  esc_op_t push_op,
	input  logic    pop,
	output logic    full,
	output logic    head_valid,
	output esc_op_t head_op
);

	esc_op_t              mem_q [QUEUE_DEPTH];
	logic [QPTR_BITS-1:0] wr_ptr_q;
	logic [QPTR_BITS-1:0] rd_ptr_q;
	logic [QPTR_BITS:0]   count_q;

	assign full       = (count_q == (QPTR_BITS+1)'(QUEUE_DEPTH));
	assign head_valid = (count_q != '0);
	assign head_op    = mem_q[rd_ptr_q];

	// storage
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_op;
		end
	end

	// pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

/* rtl/cesc_back.sv */
// ----------------------------------------------------------------------------
// cesc_back
// Takes operations from the queue, emits their results into the output register
// one word per cycle while out_stall is low; keeps the decoded length counter.
// ----------------------------------------------------------------------------
module cesc_back
	import cesc_pkg::*;
#(
	parameter int unsigned LENGTH_BITS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        head_valid,
	input  esc_op_t     head_op,
	output logic        pop,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [7:0]  out_byte,
	output logic        end_marker,
	output logic [15:0] decoded_length,
	output logic        last_of_run
);

	logic [LENGTH_BITS-1:0] count_q;
	logic                   phase_q;
	logic                   out_valid_q;
	logic [7:0]             byte_q;
	logic                   end_q;
	logic [15:0]            len_q;
	logic                   last_q;

	logic                   load;
	logic                   last;
	logic                   is_end;
	logic [7:0]             sel_byte;
	logic [LENGTH_BITS-1:0] cnt_inc;
	logic [LENGTH_BITS-1:0] len_src;
	logic [15:0]            len_rep;

	assign load     = head_valid && (!out_valid_q || !out_stall);
	assign last     = phase_q || !head_op.two;
	assign is_end   = phase_q ? head_op.end1 : head_op.end0;
	assign sel_byte = phase_q ? head_op.byte1 : head_op.byte0;
	assign cnt_inc  = (count_q != '1) ? count_q + 1'b1 : count_q;
	assign len_src  = is_end ? count_q : cnt_inc;
	assign pop      = load && last;

	// reported length saturates at the 16-bit port maximum or the counter maximum, whichever is lower
	generate
		if (LENGTH_BITS > 16) begin : g_len_wide
			assign len_rep = (|len_src[LENGTH_BITS-1:16]) ? 16'hFFFF : len_src[15:0];
		end else if (LENGTH_BITS == 16) begin : g_len_eq
			assign len_rep = len_src;
		end else begin : g_len_narrow
			assign len_rep = {{(16-LENGTH_BITS){1'b0}}, len_src};
		end
	endgenerate

	// result sequencing and length count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			phase_q     <= 1'b0;
			count_q     <= '0;
		end else begin
			if (load) begin
				out_valid_q <= 1'b1;
				phase_q     <= !last;
				count_q     <= is_end ? '0 : cnt_inc;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// output word
	always_ff @(posedge clk) begin
		if (load) begin
			byte_q <= is_end ? 8'd0 : sel_byte;
			end_q  <= is_end;
			len_q  <= len_rep;
			last_q <= last;
		end
	end

	assign out_valid      = out_valid_q;
	assign out_byte       = byte_q;
	assign end_marker     = end_q;
	assign decoded_length = len_q;
	assign last_of_run    = last_q;

endmodule

/* rtl/c_escape_sequence_decoder.sv */
// An accepted word passes through the queue into the output register. One input
// word is taken per cycle while each yields one result and the output does not
// stall; a word that yields two results holds the single output register for both.
// A four-entry queue lets the front keep accepting while the output stalls, until it is full.
// Reset (arst_n low) returns scan state, queue and length counter to empty.
// ----------------------------------------------------------------------------
// c_escape_sequence_decoder
// Decodes C string escape sequences byte by byte and reports the decoded
// length with an end marker at each terminating zero byte.
// ----------------------------------------------------------------------------
module c_escape_sequence_decoder
	import cesc_pkg::*;
#(
	parameter int unsigned LENGTH_BITS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  in_byte,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [7:0]  out_byte,
	output logic        end_marker,
	output logic [15:0] decoded_length,
	output logic        last_of_run
);

	logic    push;
	esc_op_t push_op;
	logic    pop;
	logic    q_full;
	logic    head_valid;
	esc_op_t head_op;

	// classify incoming words
	cesc_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_byte  (in_byte),
		.q_full   (q_full),
		.in_stall (in_stall),
		.push     (push),
		.push_op  (push_op)
	);

	// decouple front and back
	cesc_fifo u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_op    (push_op),
		.pop        (pop),
		.full       (q_full),
		.head_valid (head_valid),
		.head_op    (head_op)
	);

	// emit results
	cesc_back #(
		.LENGTH_BITS (LENGTH_BITS)
	) u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.head_valid     (head_valid),
		.head_op        (head_op),
		.pop            (pop),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.out_byte       (out_byte),
		.end_marker     (end_marker),
		.decoded_length (decoded_length),
		.last_of_run    (last_of_run)
	);

	// the queue never takes a word when full
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(push && q_full))
		else $error("queue overflow");

	// the end marker always closes its run and carries a zero byte
	a_end_last: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && end_marker) |-> (last_of_run && out_byte == 8'd0))
		else $error("end marker malformed");

	// a decoded byte always counts at least itself
	a_len_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !end_marker) |-> (decoded_length != 16'd0))
		else $error("decoded byte with zero length");

	// a first result that is not last is followed by its partner from the same op
	a_pair_follows: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_stall && !last_of_run) |=> (out_valid && last_of_run))
		else $error("second result missing");

endmodule
